### hdl/brng_pkg.sv
// Shared types and codes for the bitmap range engine.
// No dependencies; used by bitmap_range_engine.
`timescale 1ns / 1ps

package brng_pkg;

    // request codes carried in s_tuser
    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_SET   = 3'd2;
    localparam logic [2:0] REQ_MOVE  = 3'd3;
    localparam logic [2:0] REQ_FIND  = 3'd4;

    // bit positions handled by the walker (dst + count - 1 fits)
    localparam int POS_W   = 12;
    localparam int COUNT_W = 12;

    typedef enum logic [3:0] {
        S_CLR,   // clearing sweep after reset
        S_IDLE,
        S_CHECK, // range checks, word ops
        S_RDW,   // word read data return
        S_DIVD,  // dst position split into word / offset
        S_DIVS,  // src position split into word / offset
        S_SRC,   // fetch source bit or test bit
        S_DST,   // write destination bit
        S_LDW,   // word cache fill
        S_FIN    // hand result to output register
    } state_t;

endpackage

### hdl/brng_divider.sv
// Bit-serial restoring divider by the constant word width.
// Splits a flat bit address into word and offset; no package dependencies.
`timescale 1ns / 1ps

module brng_divider #(
    parameter int WBITS = 32,
    parameter int QW    = 12,
    parameter int RW    = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    output logic          done,
    output logic [QW-1:0] quot,
    output logic [RW-1:0] remainder
);

    localparam int CW = $clog2(QW + 1);

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [QW-1:0] dvd_reg;
    logic [QW-1:0] quot_reg;
    logic [RW-1:0] rem_reg;
    logic [RW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, dvd_reg[QW-1]};
    assign ge    = trial >= (RW + 1)'(WBITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CW'(QW);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg  <= {dvd_reg[QW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], ge};
            rem_reg  <= ge ? RW'(trial - (RW + 1)'(WBITS)) : RW'(trial);
        end
    end

    assign done      = done_reg;
    assign quot      = quot_reg;
    assign remainder = rem_reg;

endmodule

### hdl/brng_store.sv
// Bitmap word store: one write port, one registered read port.
// No package dependencies.
`timescale 1ns / 1ps

module brng_store #(
    parameter int WORDS = 64,
    parameter int WBITS = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WBITS-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WBITS-1:0] rdata
);

    logic [WBITS-1:0] mem [WORDS];
    logic [WBITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bitmap_range_engine.sv
// Bitmap range engine: a STORE_WORDS x WORD_BITS bit store with word
// write/read, range set/clear, overlap-safe range move and find-last.
// Uses brng_pkg, brng_divider and brng_store.
`timescale 1ns / 1ps

// After reset the store is swept to zero word by word, with s_tready
// low. A word write passes the check and finish states; a word read
// adds a read return state before the output register. Set, move and
// find last split their start bit addresses into word and offset with
// a bit-serial divider, then walk the range one bit per step from a
// one-word cache in front of the store: set and find reload the cache
// for each word crossed; a move fetches the source bit, then writes the
// destination bit, reloading whenever the two sit in different words.
// One request is in flight at a time; a new request is taken while the
// previous result waits on the master side.
module bitmap_range_engine #(
    parameter int STORE_WORDS = 64,
    parameter int WORD_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // word_index[5:0] write_data[37:6] dst_bit[48:38] src_bit[59:49]
    // bit_count[71:60] bit_value[72] zero[79:73]
    input  logic [79:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[31:0] found_position[43:32] status[44] zero[47:45]
    output logic [47:0] m_tdata
);

    localparam int AW    = $clog2(STORE_WORDS);
    localparam int OW    = $clog2(WORD_BITS);
    localparam int TOTAL = STORE_WORDS * WORD_BITS;
    localparam int TBW   = $clog2(TOTAL + 1);
    localparam int CW    = (TBW > 13) ? TBW : 13;
    localparam int PW    = brng_pkg::POS_W;
    localparam int NW    = brng_pkg::COUNT_W;

    brng_pkg::state_t state_reg, state_next;

    // captured request
    logic [2:0]           req_reg, req_next;
    logic [5:0]           widx_reg, widx_next;
    logic [31:0]          wdata_reg, wdata_next;
    logic [10:0]          dst_reg, dst_next;
    logic [10:0]          src_reg, src_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic                 val_reg, val_next;

    // walker
    logic [AW-1:0]        dw_reg, dw_next, sw_reg, sw_next;
    logic [OW-1:0]        do_reg, do_next, so_reg, so_next;
    logic [NW-1:0]        rem_reg, rem_next;
    logic                 bit_reg, bit_next;
    logic                 ret_dst_reg, ret_dst_next;

    // one-word cache
    logic [AW-1:0]        cur_addr_reg, cur_addr_next, ld_addr_reg, ld_addr_next;
    logic [WORD_BITS-1:0] cur_data_reg, cur_data_next;
    logic                 cur_ok_reg, cur_ok_next;

    logic [AW-1:0]        clr_reg, clr_next;

    // result
    logic [31:0]          rd_reg, rd_next;
    logic [NW-1:0]        found_reg, found_next;
    logic                 status_reg, status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [47:0]          out_reg, out_next;

    // store and divider hookups
    logic                 st_we, st_re;
    logic [AW-1:0]        st_waddr, st_raddr;
    logic [WORD_BITS-1:0] st_wdata, st_rdata;
    logic                 div_start, div_done;
    logic [PW-1:0]        div_in, div_q;
    logic [OW-1:0]        div_r;

    // derived request terms
    logic                 is_find, down;
    logic [PW-1:0]        dst_start, src_start;
    logic [CW-1:0]        dst_end, src_end;
    logic                 dst_over, src_over, cnt_over, widx_ok;
    logic                 src_hit, dst_hit;
    logic [WORD_BITS-1:0] merged;

    assign is_find   = (req_reg == brng_pkg::REQ_FIND);
    assign down      = is_find || (req_reg == brng_pkg::REQ_MOVE && dst_reg > src_reg);
    assign dst_start = down ? PW'(dst_reg) + cnt_reg - 1'b1 : PW'(dst_reg);
    assign src_start = is_find ? cnt_reg - 1'b1
                     : (down ? PW'(src_reg) + cnt_reg - 1'b1 : PW'(src_reg));
    assign dst_end   = CW'(dst_reg) + CW'(cnt_reg);
    assign src_end   = CW'(src_reg) + CW'(cnt_reg);
    assign dst_over  = dst_end > CW'(TOTAL);
    assign src_over  = src_end > CW'(TOTAL);
    assign cnt_over  = CW'(cnt_reg) > CW'(TOTAL);
    assign widx_ok   = CW'(widx_reg) < CW'(STORE_WORDS);
    assign src_hit   = cur_ok_reg && (cur_addr_reg == sw_reg);
    assign dst_hit   = cur_ok_reg && (cur_addr_reg == dw_reg);

    always_comb
    begin
        merged         = cur_data_reg;
        merged[do_reg] = bit_reg;
    end

    // divider picks src for the second split and for find
    assign div_in = (state_reg == brng_pkg::S_DIVD || is_find) ? src_start : dst_start;

    brng_divider #(
        .WBITS (WORD_BITS),
        .QW    (PW),
        .RW    (OW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_in),
        .done      (div_done),
        .quot      (div_q),
        .remainder (div_r)
    );

    brng_store #(
        .WORDS (STORE_WORDS),
        .WBITS (WORD_BITS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brng_pkg::S_CLR;
            clr_reg       <= '0;
            cur_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cur_ok_reg    <= cur_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        widx_reg     <= widx_next;
        wdata_reg    <= wdata_next;
        dst_reg      <= dst_next;
        src_reg      <= src_next;
        cnt_reg      <= cnt_next;
        val_reg      <= val_next;
        dw_reg       <= dw_next;
        do_reg       <= do_next;
        sw_reg       <= sw_next;
        so_reg       <= so_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        ret_dst_reg  <= ret_dst_next;
        cur_addr_reg <= cur_addr_next;
        ld_addr_reg  <= ld_addr_next;
        cur_data_reg <= cur_data_next;
        rd_reg       <= rd_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        widx_next      = widx_reg;
        wdata_next     = wdata_reg;
        dst_next       = dst_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        dw_next        = dw_reg;
        do_next        = do_reg;
        sw_next        = sw_reg;
        so_next        = so_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        ret_dst_next   = ret_dst_reg;
        cur_addr_next  = cur_addr_reg;
        ld_addr_next   = ld_addr_reg;
        cur_data_next  = cur_data_reg;
        cur_ok_next    = cur_ok_reg;
        clr_next       = clr_reg;
        rd_next        = rd_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        st_we          = 1'b0;
        st_waddr       = dw_reg;
        st_wdata       = merged;
        st_re          = 1'b0;
        st_raddr       = sw_reg;
        div_start      = 1'b0;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            brng_pkg::S_CLR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(STORE_WORDS - 1))
                    state_next = brng_pkg::S_IDLE;
            end

            brng_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    req_next    = s_tuser;
                    widx_next   = s_tdata[5:0];
                    wdata_next  = s_tdata[37:6];
                    dst_next    = s_tdata[48:38];
                    src_next    = s_tdata[59:49];
                    cnt_next    = s_tdata[71:60];
                    val_next    = s_tdata[72];
                    rd_next     = '0;
                    found_next  = '0;
                    status_next = 1'b0;
                    cur_ok_next = 1'b0;
                    state_next  = brng_pkg::S_CHECK;
                end
            end

            brng_pkg::S_CHECK:
            begin
                rem_next   = cnt_reg;
                bit_next   = val_reg;
                state_next = brng_pkg::S_FIN;
                case (req_reg)
                    brng_pkg::REQ_WRITE:
                    begin
                        if (widx_ok)
                        begin
                            st_we    = 1'b1;
                            st_waddr = AW'(widx_reg);
                            st_wdata = WORD_BITS'(wdata_reg);
                        end
                        else
                            status_next = 1'b1;
                    end
                    brng_pkg::REQ_READ:
                    begin
                        if (widx_ok)
                        begin
                            st_re      = 1'b1;
                            st_raddr   = AW'(widx_reg);
                            state_next = brng_pkg::S_RDW;
                        end
                        else
                            status_next = 1'b1;
                    end
                    brng_pkg::REQ_SET:
                    begin
                        if (dst_over)
                            status_next = 1'b1;
                        else if (cnt_reg != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = brng_pkg::S_DIVD;
                        end
                    end
                    brng_pkg::REQ_MOVE:
                    begin
                        if (dst_over || src_over)
                            status_next = 1'b1;
                        else if (cnt_reg != '0 && dst_reg != src_reg)
                        begin
                            div_start  = 1'b1;
                            state_next = brng_pkg::S_DIVD;
                        end
                    end
                    brng_pkg::REQ_FIND:
                    begin
                        if (cnt_over)
                            status_next = 1'b1;
                        else if (cnt_reg != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = brng_pkg::S_DIVS;
                        end
                    end
                    default:
                    begin
                        // unknown request: all-zero result
                    end
                endcase
            end

            brng_pkg::S_RDW:
            begin
                rd_next    = 32'(st_rdata);
                state_next = brng_pkg::S_FIN;
            end

            brng_pkg::S_DIVD:
            begin
                if (div_done)
                begin
                    dw_next = AW'(div_q);
                    do_next = div_r;
                    if (req_reg == brng_pkg::REQ_MOVE)
                    begin
                        div_start  = 1'b1;
                        state_next = brng_pkg::S_DIVS;
                    end
                    else
                        state_next = brng_pkg::S_DST;
                end
            end

            brng_pkg::S_DIVS:
            begin
                if (div_done)
                begin
                    sw_next    = AW'(div_q);
                    so_next    = div_r;
                    state_next = brng_pkg::S_SRC;
                end
            end

            brng_pkg::S_SRC:
            begin
                if (!src_hit)
                begin
                    st_re        = 1'b1;
                    st_raddr     = sw_reg;
                    ld_addr_next = sw_reg;
                    ret_dst_next = 1'b0;
                    state_next   = brng_pkg::S_LDW;
                end
                else if (is_find)
                begin
                    if (cur_data_reg[so_reg] == val_reg)
                    begin
                        found_next = rem_reg;
                        state_next = brng_pkg::S_FIN;
                    end
                    else if (rem_reg == NW'(1))
                        state_next = brng_pkg::S_FIN;
                    else
                    begin
                        rem_next = rem_reg - 1'b1;
                        if (so_reg == '0)
                        begin
                            so_next = OW'(WORD_BITS - 1);
                            sw_next = sw_reg - 1'b1;
                        end
                        else
                            so_next = so_reg - 1'b1;
                    end
                end
                else
                begin
                    bit_next   = cur_data_reg[so_reg];
                    state_next = brng_pkg::S_DST;
                end
            end

            brng_pkg::S_DST:
            begin
                if (!dst_hit)
                begin
                    st_re        = 1'b1;
                    st_raddr     = dw_reg;
                    ld_addr_next = dw_reg;
                    ret_dst_next = 1'b1;
                    state_next   = brng_pkg::S_LDW;
                end
                else
                begin
                    // write-through keeps cache and store in step
                    st_we         = 1'b1;
                    st_waddr      = dw_reg;
                    st_wdata      = merged;
                    cur_data_next = merged;
                    rem_next      = rem_reg - 1'b1;
                    if (down)
                    begin
                        if (do_reg == '0)
                        begin
                            do_next = OW'(WORD_BITS - 1);
                            dw_next = dw_reg - 1'b1;
                        end
                        else
                            do_next = do_reg - 1'b1;
                        if (so_reg == '0)
                        begin
                            so_next = OW'(WORD_BITS - 1);
                            sw_next = sw_reg - 1'b1;
                        end
                        else
                            so_next = so_reg - 1'b1;
                    end
                    else
                    begin
                        if (do_reg == OW'(WORD_BITS - 1))
                        begin
                            do_next = '0;
                            dw_next = dw_reg + 1'b1;
                        end
                        else
                            do_next = do_reg + 1'b1;
                        if (so_reg == OW'(WORD_BITS - 1))
                        begin
                            so_next = '0;
                            sw_next = sw_reg + 1'b1;
                        end
                        else
                            so_next = so_reg + 1'b1;
                    end
                    if (rem_reg == NW'(1))
                        state_next = brng_pkg::S_FIN;
                    else if (req_reg == brng_pkg::REQ_MOVE)
                        state_next = brng_pkg::S_SRC;
                end
            end

            brng_pkg::S_LDW:
            begin
                cur_data_next = st_rdata;
                cur_addr_next = ld_addr_reg;
                cur_ok_next   = 1'b1;
                state_next    = ret_dst_reg ? brng_pkg::S_DST : brng_pkg::S_SRC;
            end

            brng_pkg::S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = {3'b000, status_reg, found_reg, rd_reg};
                    out_valid_next = 1'b1;
                    state_next     = brng_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = brng_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    // one request in flight: no accept in the cycle after an accept
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while engine busy");

    // store is written only by the sweep, a word write or a bit write
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> (state_reg == brng_pkg::S_CLR || state_reg == brng_pkg::S_CHECK
                   || state_reg == brng_pkg::S_DST))
        else $error("store write outside a writing state");

    // a new result only comes out of the finish step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == brng_pkg::S_FIN))
        else $error("result raised outside finish");
`endif

endmodule
